// ===== rtl/can_bts_pkg.sv =====
// Shared widths, search constants, sequencer states and timing word packing
// for the CAN bit timing search block. No dependencies.
package can_bts_pkg;

  localparam int CLK_W  = 27;
  localparam int RATE_W = 20;
  localparam int DIV_W  = 4;
  localparam int WORD_W = 15;
  localparam int QM1_W  = 6;
  localparam int SEG_W  = 5;

  localparam logic [SEG_W-1:0] SEGS_MIN = 5'd3;
  localparam logic [SEG_W-1:0] SEGS_MAX = 5'd17;
  localparam logic [SEG_W-1:0] SJW_MAX  = 5'd3;

  localparam logic [CLK_W-1:0] CLK_RESET = 27'd48000000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH,
    ST_PUSH
  } bts_state_t;

  typedef struct packed {
    logic             found;
    logic [DIV_W-1:0] div_code;
    logic [QM1_W-1:0] qm1_code;
    logic [SEG_W-1:0] segs;
  } search_res_t;

  function automatic logic [WORD_W-1:0] pack_timing(logic [QM1_W-1:0] qm1,
                                                    logic [SEG_W-1:0] segs);
    logic [SEG_W-1:0] rest;
    logic [SEG_W-1:0] s1;
    logic [SEG_W-1:0] s2;
    logic [SEG_W-1:0] sjw;
    rest = segs - SEGS_MIN;
    s1   = rest >> 1;
    s2   = rest - s1;
    sjw  = (s1 > SJW_MAX) ? SJW_MAX : s1;
    return {s2[2:0], s1[3:0], sjw[1:0], qm1};
  endfunction

endpackage

// ===== rtl/can_bts_divider.sv =====
// Restoring divider, one quotient bit per cycle: clocks per bit from the
// peripheral clock and the bit rate. Uses can_bts_pkg.
module can_bts_divider import can_bts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CLK_W-1:0]  dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic              done,
  output logic [CLK_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(CLK_W);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [CLK_W-1:0]  quo;
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] dvsr;
  logic [RATE_W:0]   rem_sh;
  logic [RATE_W:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem, quo[CLK_W-1]};
  assign ge      = rem_sh >= {1'b0, dvsr};
  assign rem_sub = rem_sh - {1'b0, dvsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(CLK_W - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  // operands are captured at start; the input word may change afterwards
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (run) begin
      quo <= {quo[CLK_W-2:0], ge};
      rem <= ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
    end
  end

endmodule

// ===== rtl/can_bts_search.sv =====
// Search sequencer (uses can_bts_pkg): walks divider, quanta and segment
// counts in order with one running product until an exact match or the end.
module can_bts_search import can_bts_pkg::*; #(
  parameter int DIV_LIMIT    = 15,
  parameter int QUANTA_LIMIT = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CLK_W-1:0] cpb,
  output logic             done,
  output search_res_t      res
);

  localparam int DW     = $clog2(DIV_LIMIT + 1);
  localparam int QW     = $clog2(QUANTA_LIMIT + 1);
  localparam int STEP_W = $clog2(QUANTA_LIMIT * (DIV_LIMIT + 1) + 2);
  localparam int PW     = $clog2(17 * QUANTA_LIMIT * (DIV_LIMIT + 1) + 1);

  logic              run;
  logic              found;
  logic [DW-1:0]     d;
  logic [QW-1:0]     q;
  logic [SEG_W-1:0]  segs;
  logic [STEP_W-1:0] step;
  logic [PW-1:0]     p;

  logic              run_next;
  logic              done_next;
  logic              found_next;
  logic [DW-1:0]     d_next;
  logic [QW-1:0]     q_next;
  logic [SEG_W-1:0]  segs_next;
  logic [STEP_W-1:0] step_next;
  logic [PW-1:0]     p_next;

  logic [STEP_W-1:0] dp1;
  logic [STEP_W-1:0] step_new;
  logic [DW+DIV_W-1:0] d_ext;
  logic [QW+QM1_W-1:0] qm1_ext;

  assign dp1 = STEP_W'(d) + STEP_W'(1);

  always_comb begin
    run_next   = run;
    done_next  = 1'b0;
    found_next = found;
    d_next     = d;
    q_next     = q;
    segs_next  = segs;
    step_next  = step;
    p_next     = p;
    step_new   = '0;
    if (start) begin
      run_next   = 1'b1;
      found_next = 1'b0;
      d_next     = '0;
      q_next     = QW'(1);
      segs_next  = SEGS_MIN;
      step_next  = STEP_W'(1);
      p_next     = PW'(3);
    end else if (run) begin
      priority if (CLK_W'(p) == cpb) begin
        run_next   = 1'b0;
        done_next  = 1'b1;
        found_next = 1'b1;
      end else if (segs != SEGS_MAX) begin
        segs_next = segs + 1'b1;
        p_next    = p + PW'(step);
      end else if (q != QW'(QUANTA_LIMIT)) begin
        step_new  = step + dp1;
        q_next    = q + 1'b1;
        segs_next = SEGS_MIN;
        step_next = step_new;
        p_next    = PW'(step_new) + (PW'(step_new) << 1);
      end else if (d != DW'(DIV_LIMIT)) begin
        step_new  = dp1 + STEP_W'(1);
        d_next    = d + 1'b1;
        q_next    = QW'(1);
        segs_next = SEGS_MIN;
        step_next = step_new;
        p_next    = PW'(step_new) + (PW'(step_new) << 1);
      end else begin
        run_next  = 1'b0;
        done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      run   <= run_next;
      done  <= done_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    d    <= d_next;
    q    <= q_next;
    segs <= segs_next;
    step <= step_next;
    p    <= p_next;
  end

  assign d_ext   = {{DIV_W{1'b0}}, d};
  assign qm1_ext = {{QM1_W{1'b0}}, q} - 1'b1;

  assign res.found    = found;
  assign res.div_code = d_ext[DIV_W-1:0];
  assign res.qm1_code = qm1_ext[QM1_W-1:0];
  assign res.segs     = segs;

endmodule

// ===== rtl/can_bit_timing_search_unit.sv =====
// CAN bit timing search unit, top level.
// Uses can_bts_pkg, can_bts_divider and can_bts_search.
//
// Usage:
//   cfg_we/cfg_wdata write the peripheral clock rate in Hz (27 bits); write
//   only while the unit is idle. Reset loads 48000000.
//   Input channel (in_valid/in_ready, bit_rate) takes one word: a requested
//   bit rate. Output channel (out_valid/out_ready) returns one word per
//   input: clock_divider, timing_word and found.
// Timing:
//   One word at a time; in_ready is high only while the unit is idle.
//   A zero bit rate skips the divider and search and goes to the output
//   register with found low. Otherwise the divider produces one quotient bit a
//   cycle, then the search tests one candidate product per cycle, across
//   (DIV_LIMIT+1)*QUANTA_LIMIT*15 candidates at most (7680 with defaults).
//   The search uses a single add/compare datapath.
// Stalls:
//   The result sits in an output register; if out_ready is low when the next
//   result is ready, the unit waits and holds in_ready low.
// Reset: synchronous, clears control state and the output valid.
module can_bit_timing_search_unit import can_bts_pkg::*; #(
  parameter int DIV_LIMIT    = 15,
  parameter int QUANTA_LIMIT = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CLK_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RATE_W-1:0] bit_rate,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIV_W-1:0]  clock_divider,
  output logic [WORD_W-1:0] timing_word,
  output logic              found
);

  bts_state_t state;
  bts_state_t state_next;

  logic [CLK_W-1:0] peripheral_clock_hz;
  logic             div_start;
  logic             div_done;
  logic [CLK_W-1:0] cpb;
  logic             srch_start;
  logic             srch_done;
  search_res_t      srch_res;
  search_res_t      res;
  search_res_t      res_next;
  logic             load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      peripheral_clock_hz <= CLK_RESET;
    end else if (cfg_we) begin
      peripheral_clock_hz <= cfg_wdata;
    end
  end

  can_bts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (peripheral_clock_hz),
    .divisor  (bit_rate),
    .done     (div_done),
    .quotient (cpb)
  );

  can_bts_search #(
    .DIV_LIMIT    (DIV_LIMIT),
    .QUANTA_LIMIT (QUANTA_LIMIT)
  ) u_search (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .cpb   (cpb),
    .done  (srch_done),
    .res   (srch_res)
  );

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    srch_start = 1'b0;
    load_out   = 1'b0;
    res_next   = res;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (bit_rate == '0) begin
            res_next   = '0;
            state_next = ST_PUSH;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          srch_start = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_done) begin
          res_next   = srch_res;
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // not-found words carry zero fields
  always_ff @(posedge clk) begin
    if (load_out) begin
      found         <= res.found;
      clock_divider <= res.found ? res.div_code : '0;
      timing_word   <= res.found ? pack_timing(res.qm1_code, res.segs) : '0;
    end
  end

endmodule
